@@ rtl/resi_pkg.sv @@
// Shared types, widths and helpers for the rectangle edge / segment intersect block.
// Used by every other file in rtl/.
`default_nettype none

package resi_pkg;

	localparam int COORD_BITS = 24;
	localparam int OP_BITS    = 3;
	localparam int T_BITS     = 17;              // unsigned Q1.16
	localparam int T_FRAC     = T_BITS - 1;
	localparam int VW         = COORD_BITS + 1;  // edge start / direction
	localparam int DW         = COORD_BITS + 2;  // start difference
	localparam int PW         = VW + DW;         // one product
	localparam int XW         = PW + 1;          // cross product
	localparam int RW         = XW + 1;          // divider remainder
	localparam int MW         = VW + T_BITS + 1; // direction times t

	typedef enum logic [OP_BITS-1:0] {
		OP_TOP    = 3'd0,
		OP_BOTTOM = 3'd1,
		OP_LEFT   = 3'd2,
		OP_RIGHT  = 3'd3,
		OP_SEG    = 3'd4
	} op_t;

	typedef struct packed {
		logic                 hit;
		logic signed [VW-1:0] s1x;
		logic signed [VW-1:0] s1y;
		logic signed [VW-1:0] v1x;
		logic signed [VW-1:0] v1y;
	} side_t;

	typedef struct packed {
		logic [RW-1:0]     den;
		logic [RW-1:0]     r1;
		logic [RW-1:0]     r2;
		logic [T_BITS-1:0] q1;
		logic [T_BITS-1:0] q2;
		side_t             side;
	} div_t;

	typedef struct packed {
		logic                         hit;
		logic [T_BITS-1:0]            t_first;
		logic [T_BITS-1:0]            t_second;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} res_t;

	// n / den lies in [0, 1]; den is known to be nonzero
	function automatic logic in_unit(input logic signed [XW-1:0] n,
			input logic signed [XW-1:0] den);
		if (!den[XW-1]) begin
			return !n[XW-1] && (n <= den);
		end
		return (n[XW-1] || (n == '0)) && (n >= den);
	endfunction

	function automatic logic [RW-1:0] mag(input logic signed [XW-1:0] x);
		logic [XW-1:0] m;
		m = x[XW-1] ? -x : x;
		return RW'(m);
	endfunction

endpackage

`default_nettype wire

@@ rtl/resi_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on resi_pkg for field widths.
`default_nettype none

interface resi_in_if;
	import resi_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [OP_BITS-1:0]           opcode;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] d_x;
	logic signed [COORD_BITS-1:0] d_y;
	modport source(output valid, opcode, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
		input ready);
	modport sink(input valid, opcode, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
		output ready);
endinterface

interface resi_out_if;
	import resi_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [T_BITS-1:0]            t_first;
	logic [T_BITS-1:0]            t_second;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	modport source(output valid, hit, t_first, t_second, point_x, point_y, input ready);
	modport sink(input valid, hit, t_first, t_second, point_x, point_y, output ready);
endinterface

`default_nettype wire

@@ rtl/resi_div_cell.sv @@
// One restoring division step for both t quotients, registered.
// Cells chain into the divider row; depends on resi_pkg.
`default_nettype none

module resi_div_cell #(
	parameter bit FIRST = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  resi_pkg::div_t       data_in,
	output logic                 valid_out,
	output resi_pkg::div_t       data_out
);
	import resi_pkg::*;

	logic [RW-1:0] sh1, sh2;
	logic          ge1, ge2;
	div_t          nxt;

	always_comb begin
		// first step compares the integer bit, the rest shift in a fraction bit
		sh1 = FIRST ? data_in.r1 : {data_in.r1[RW-2:0], 1'b0};
		sh2 = FIRST ? data_in.r2 : {data_in.r2[RW-2:0], 1'b0};
		ge1 = sh1 >= data_in.den;
		ge2 = sh2 >= data_in.den;
		nxt = data_in;
		nxt.r1 = ge1 ? sh1 - data_in.den : sh1;
		nxt.r2 = ge2 ? sh2 - data_in.den : sh2;
		nxt.q1 = {data_in.q1[T_BITS-2:0], ge1};
		nxt.q2 = {data_in.q2[T_BITS-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_out <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/resi_point.sv @@
// Hit point: direction times t (registered), then round and saturate.
// Takes the divider row output; depends on resi_pkg.
`default_nettype none

module resi_point (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  resi_pkg::div_t data_in,
	output logic           valid_out,
	output resi_pkg::res_t res
);
	import resi_pkg::*;

	localparam int SW = VW + 4;
	localparam logic signed [MW:0]   RND  = (MW + 1)'(1) <<< (T_FRAC - 1);
	localparam logic signed [SW-1:0] PMAX = {{(SW - COORD_BITS + 1){1'b0}},
		{(COORD_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN = ~PMAX;

	logic signed [MW-1:0]     prodx_s1, prody_s1;
	logic signed [VW-1:0]     s1x_s1, s1y_s1;
	logic [T_BITS-1:0]        t1_s1, t2_s1;
	logic                     hit_s1;
	logic signed [MW-1:0]     tval;

	function automatic logic signed [COORD_BITS-1:0] rnd_sat(
			input logic signed [VW-1:0] s, input logic signed [MW-1:0] p);
		logic signed [MW:0]   b;
		logic signed [SW-1:0] sum;
		b = (MW + 1)'(p) + RND;
		sum = SW'(s) + SW'(b >>> T_FRAC);
		if (sum > PMAX) begin
			sum = PMAX;
		end else if (sum < PMIN) begin
			sum = PMIN;
		end
		return sum[COORD_BITS-1:0];
	endfunction

	assign tval = MW'($signed({1'b0, data_in.q1}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prodx_s1 <= MW'(data_in.side.v1x) * tval;
			prody_s1 <= MW'(data_in.side.v1y) * tval;
			s1x_s1   <= data_in.side.s1x;
			s1y_s1   <= data_in.side.s1y;
			t1_s1    <= data_in.q1;
			t2_s1    <= data_in.q2;
			hit_s1   <= data_in.side.hit;
		end
	end

	// every field reads zero on a miss
	always_comb begin
		res.hit      = hit_s1;
		res.t_first  = hit_s1 ? t1_s1 : '0;
		res.t_second = hit_s1 ? t2_s1 : '0;
		res.point_x  = hit_s1 ? rnd_sat(s1x_s1, prodx_s1) : '0;
		res.point_y  = hit_s1 ? rnd_sat(s1y_s1, prody_s1) : '0;
	end

endmodule

`default_nettype wire

@@ rtl/resi_top.sv @@
// Top level of the rectangle edge / segment intersect block.
// Instantiates resi_div_cell and resi_point; depends on resi_pkg and resi_if.
`default_nettype none

// Without stalls, one item is accepted and one result leaves per clock, in order.
// An item passes 23 registers: four front stages (edge setup, products,
// cross products, hit check and edge select), a row of 17 division cells
// that produce one bit of both t values per cell, the point multiply stage
// and the output register.
// A two-entry output buffer keeps input ready high while a finished result
// waits to be taken; ready drops only when both entries are full.
module rect_edge_segment_intersect_top (
	input  logic              clk,
	input  logic              arst_n,
	resi_in_if.sink           item,
	resi_out_if.source        result
);
	import resi_pkg::*;

	logic en;

	// stage 1: edges
	logic                 v_s1, op_ok_s1, use_b_s1;
	logic signed [VW-1:0] s1x_s1, s1y_s1, v1x_s1, v1y_s1, v2x_s1, v2y_s1;
	logic signed [DW-1:0] wax_s1, way_s1, wbx_s1, wby_s1;
	// stage 2: products
	logic                 v_s2, op_ok_s2, use_b_s2;
	side_t                side_s2;
	logic signed [PW-1:0] pd1_s2, pd2_s2;
	logic signed [PW-1:0] pa1_s2, pa2_s2, pa3_s2, pa4_s2;
	logic signed [PW-1:0] pb1_s2, pb2_s2, pb3_s2, pb4_s2;
	// stage 3: cross products
	logic                 v_s3, op_ok_s3, use_b_s3;
	side_t                side_s3;
	logic signed [XW-1:0] den_s3, na1_s3, na2_s3, nb1_s3, nb2_s3;
	// stage 4: select
	logic                 v_s4;
	div_t                 d_s4;

	logic signed [VW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	logic signed [VW-1:0] s1x, s1y, v1x, v1y, v2x, v2y, sax, say, sbx, sby;
	logic                 op_ok, use_b;
	logic                 den_nz, hit_a, hit_b;
	div_t                 d_nxt;

	assign ax = VW'(item.a_x);
	assign ay = VW'(item.a_y);
	assign bx = VW'(item.b_x);
	assign by = VW'(item.b_y);
	assign cx = VW'(item.c_x);
	assign cy = VW'(item.c_y);
	assign dx = VW'(item.d_x);
	assign dy = VW'(item.d_y);

	always_comb begin
		s1x = '0; s1y = '0; v1x = '0; v1y = '0; v2x = '0; v2y = '0;
		sax = '0; say = '0; sbx = '0; sby = '0;
		op_ok = 1'b1;
		use_b = 1'b1;
		unique case (item.opcode) inside
			OP_TOP, OP_BOTTOM: begin
				s1x = ax - bx;
				s1y = (item.opcode == OP_TOP) ? ay - by : ay + by;
				v1x = bx + bx;
				v2y = dy + dy;
				sax = cx + dx;
				say = cy - dy;
				sbx = cx - dx;
				sby = cy - dy;
			end
			OP_LEFT, OP_RIGHT: begin
				s1x = (item.opcode == OP_LEFT) ? ax - bx : ax + bx;
				s1y = ay - by;
				v1y = by + by;
				v2x = dx + dx;
				sax = cx - dx;
				say = cy + dy;
				sbx = cx - dx;
				sby = cy - dy;
			end
			OP_SEG: begin
				s1x = ax;
				s1y = ay;
				v1x = bx;
				v1y = by;
				v2x = dx;
				v2y = dy;
				sax = cx;
				say = cy;
				use_b = 1'b0;
			end
			default: begin
				op_ok = 1'b0;
				use_b = 1'b0;
			end
		endcase
	end

	// check both candidate edges, first hit wins
	always_comb begin
		den_nz = den_s3 != '0;
		hit_a  = den_nz && in_unit(na1_s3, den_s3) && in_unit(na2_s3, den_s3);
		hit_b  = use_b_s3 && den_nz && in_unit(nb1_s3, den_s3)
			&& in_unit(nb2_s3, den_s3);
		d_nxt.den  = mag(den_s3);
		d_nxt.r1   = hit_a ? mag(na1_s3) : mag(nb1_s3);
		d_nxt.r2   = hit_a ? mag(na2_s3) : mag(nb2_s3);
		d_nxt.q1   = '0;
		d_nxt.q2   = '0;
		d_nxt.side = side_s3;
		d_nxt.side.hit = op_ok_s3 && (hit_a || hit_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_ok_s1 <= op_ok;
			use_b_s1 <= use_b;
			s1x_s1   <= s1x;
			s1y_s1   <= s1y;
			v1x_s1   <= v1x;
			v1y_s1   <= v1y;
			v2x_s1   <= v2x;
			v2y_s1   <= v2y;
			wax_s1   <= DW'(sax) - DW'(s1x);
			way_s1   <= DW'(say) - DW'(s1y);
			wbx_s1   <= DW'(sbx) - DW'(s1x);
			wby_s1   <= DW'(sby) - DW'(s1y);

			op_ok_s2     <= op_ok_s1;
			use_b_s2     <= use_b_s1;
			side_s2.hit  <= 1'b0;
			side_s2.s1x  <= s1x_s1;
			side_s2.s1y  <= s1y_s1;
			side_s2.v1x  <= v1x_s1;
			side_s2.v1y  <= v1y_s1;
			pd1_s2 <= PW'(v1x_s1) * PW'(v2y_s1);
			pd2_s2 <= PW'(v1y_s1) * PW'(v2x_s1);
			pa1_s2 <= PW'(wax_s1) * PW'(v2y_s1);
			pa2_s2 <= PW'(way_s1) * PW'(v2x_s1);
			pa3_s2 <= PW'(wax_s1) * PW'(v1y_s1);
			pa4_s2 <= PW'(way_s1) * PW'(v1x_s1);
			pb1_s2 <= PW'(wbx_s1) * PW'(v2y_s1);
			pb2_s2 <= PW'(wby_s1) * PW'(v2x_s1);
			pb3_s2 <= PW'(wbx_s1) * PW'(v1y_s1);
			pb4_s2 <= PW'(wby_s1) * PW'(v1x_s1);

			op_ok_s3 <= op_ok_s2;
			use_b_s3 <= use_b_s2;
			side_s3  <= side_s2;
			den_s3   <= XW'(pd1_s2) - XW'(pd2_s2);
			na1_s3   <= XW'(pa1_s2) - XW'(pa2_s2);
			na2_s3   <= XW'(pa3_s2) - XW'(pa4_s2);
			nb1_s3   <= XW'(pb1_s2) - XW'(pb2_s2);
			nb2_s3   <= XW'(pb3_s2) - XW'(pb4_s2);

			d_s4 <= d_nxt;
		end
	end

	// divider row
	logic [T_BITS:0] cv;
	div_t            cd [T_BITS+1];

	assign cv[0] = v_s4;
	assign cd[0] = d_s4;

	for (genvar i = 0; i < T_BITS; i++) begin : g_cell
		resi_div_cell #(
			.FIRST(i == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cv[i]),
			.data_in  (cd[i]),
			.valid_out(cv[i+1]),
			.data_out (cd[i+1])
		);
	end

	logic pv;
	res_t pd;

	resi_point u_point (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (cv[T_BITS]),
		.data_in  (cd[T_BITS]),
		.valid_out(pv),
		.res      (pd)
	);

	// output register plus skid entry
	logic ov_q, skv_q;
	res_t o_q, sk_q;

	assign en = !skv_q;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			skv_q <= 1'b0;
		end else if (skv_q) begin
			if (result.ready) begin
				skv_q <= 1'b0;
			end
		end else if (pv) begin
			if (!ov_q || result.ready) begin
				ov_q <= 1'b1;
			end else begin
				skv_q <= 1'b1;
			end
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skv_q) begin
			if (result.ready) begin
				o_q <= sk_q;
			end
		end else if (pv) begin
			if (!ov_q || result.ready) begin
				o_q <= pd;
			end else begin
				sk_q <= pd;
			end
		end
	end

	assign result.valid    = ov_q;
	assign result.hit      = o_q.hit;
	assign result.t_first  = o_q.t_first;
	assign result.t_second = o_q.t_second;
	assign result.point_x  = o_q.point_x;
	assign result.point_y  = o_q.point_y;

endmodule

`default_nettype wire

@@ dv/tb_rect_edge_segment_intersect_top.sv @@
// Testbench for rect_edge_segment_intersect_top: directed and random items with
// valid/ready bursts on both channels, checked against an in-bench intersect predictor.
// Depends on rtl/resi_pkg.sv, rtl/resi_if.sv and rtl/resi_top.sv.
`timescale 1ns / 1ps

module tb_rect_edge_segment_intersect_top;
	import resi_pkg::*;

	localparam logic [OP_BITS-1:0] OP_UNUSED_MAX = 3'd7;
	localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int QUIET_TAIL = 100;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [OP_BITS-1:0]           op;
		logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} pair_t;

	logic clk;
	logic arst_n;

	resi_in_if  item();
	resi_out_if result();

	rect_edge_segment_intersect_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source)
	);

	pair_t  pending_pairs[$];
	res_t   expected_hits[$];
	int     send_gap;
	int     take_gap;
	int     mismatches;
	longint cycles;

	function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
		if (v > CMAX) begin
			return COORD_BITS'(CMAX);
		end
		if (v < CMIN) begin
			return COORD_BITS'(CMIN);
		end
		return COORD_BITS'(v);
	endfunction

	function automatic res_t cross_segments(input longint s1x, s1y, v1x, v1y,
			input longint s2x, s2y, v2x, v2y);
		longint wx, wy, den, n1, n2, t1, t2;
		res_t r;
		r = '0;
		wx = s2x - s1x;
		wy = s2y - s1y;
		den = v1x * v2y - v1y * v2x;
		if (den == 0) begin
			return r;
		end
		n1 = wx * v2y - wy * v2x;
		n2 = wx * v1y - wy * v1x;
		if (den < 0) begin
			den = -den;
			n1 = -n1;
			n2 = -n2;
		end
		if (n1 < 0 || n2 < 0 || n1 > den || n2 > den) begin
			return r;
		end
		t1 = longint'((128'(n1) << T_FRAC) / 128'(den));
		t2 = longint'((128'(n2) << T_FRAC) / 128'(den));
		r.hit = 1'b1;
		r.t_first = T_BITS'(t1);
		r.t_second = T_BITS'(t2);
		// round half up, then saturate
		r.point_x = clamp_coord(s1x + ((v1x * t1 + 32768) >>> T_FRAC));
		r.point_y = clamp_coord(s1y + ((v1y * t1 + 32768) >>> T_FRAC));
		return r;
	endfunction

	function automatic res_t predict_hit(input pair_t p);
		longint ax, ay, bx, by, cx, cy, dx, dy, sx1, sy1, vx1, vy1;
		res_t r;
		ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
		cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
		r = '0;
		if (p.op == OP_SEG) begin
			return cross_segments(ax, ay, bx, by, cx, cy, dx, dy);
		end
		if (p.op > OP_SEG) begin
			return r;
		end
		if (p.op == OP_TOP || p.op == OP_BOTTOM) begin
			sx1 = ax - bx;
			sy1 = (p.op == OP_TOP) ? ay - by : ay + by;
			vx1 = 2 * bx;
			vy1 = 0;
			r = cross_segments(sx1, sy1, vx1, vy1, cx + dx, cy - dy, 0, 2 * dy);
			if (!r.hit) begin
				r = cross_segments(sx1, sy1, vx1, vy1, cx - dx, cy - dy, 0, 2 * dy);
			end
		end else begin
			sx1 = (p.op == OP_LEFT) ? ax - bx : ax + bx;
			sy1 = ay - by;
			vx1 = 0;
			vy1 = 2 * by;
			r = cross_segments(sx1, sy1, vx1, vy1, cx - dx, cy + dy, 2 * dx, 0);
			if (!r.hit) begin
				r = cross_segments(sx1, sy1, vx1, vy1, cx - dx, cy - dy, 2 * dx, 0);
			end
		end
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] any_coord();
		return COORD_BITS'($urandom);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] near_coord(input int span);
		return COORD_BITS'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic pair_t make_pair(input logic [OP_BITS-1:0] op,
			input longint ax, ay, bx, by, cx, cy, dx, dy);
		pair_t p;
		p.op = op;
		p.ax = COORD_BITS'(ax); p.ay = COORD_BITS'(ay);
		p.bx = COORD_BITS'(bx); p.by = COORD_BITS'(by);
		p.cx = COORD_BITS'(cx); p.cy = COORD_BITS'(cy);
		p.dx = COORD_BITS'(dx); p.dy = COORD_BITS'(dy);
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		pair_t p;
		int kind;
		int span;
		logic [OP_BITS-1:0] op;
		// overlapping boxes, every edge and the segment opcode
		for (op = OP_TOP; op <= OP_SEG; op++) begin
			pending_pairs.push_back(make_pair(op, 0, 0, 1024, 512, 512, 256, 1024, 1024));
		end
		// crossing, endpoint touches, parallel, degenerate
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 2560, 2560, 0, 2560, 2560, -2560));
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 256, 0, 256, -256, 0, 512));
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 256, 0, 0, 0, 0, 512));
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 256, 256, 100, 0, 256, 256));
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 0, 0, 10, -10, 0, 40));
		pending_pairs.push_back(make_pair(OP_SEG, 0, 0, 3, 7, 1, 0, -1, 5));
		// field extremes
		pending_pairs.push_back(make_pair(OP_SEG, CMAX, CMAX, CMAX, CMAX,
			CMAX, CMAX, CMAX, CMAX));
		pending_pairs.push_back(make_pair(OP_SEG, CMIN, CMIN, CMIN, CMIN,
			CMIN, CMIN, CMIN, CMIN));
		pending_pairs.push_back(make_pair(OP_SEG, CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
		pending_pairs.push_back(make_pair(OP_SEG, CMAX, CMIN, CMIN, CMAX,
			CMIN, CMIN, CMAX, CMAX));
		// saturated hit point from a box edge that runs past the range
		pending_pairs.push_back(make_pair(OP_TOP, CMAX, 0, CMAX, 100, CMAX, 0, CMAX, 1000));
		pending_pairs.push_back(make_pair(OP_LEFT, CMIN, CMIN, CMIN, CMIN,
			CMIN, CMIN, CMIN, CMIN));
		pending_pairs.push_back(make_pair(OP_RIGHT, 0, CMAX, CMAX, CMAX,
			CMAX, CMAX, CMAX, CMAX));
		// negative and zero half sizes
		pending_pairs.push_back(make_pair(OP_BOTTOM, 0, 0, -1024, -512, 300, 200, -800, -900));
		pending_pairs.push_back(make_pair(OP_LEFT, 0, 0, 0, 512, 0, 100, 256, 0));
		for (op = OP_BITS'(OP_SEG + 1); op <= OP_UNUSED_MAX && op > OP_SEG; op++) begin
			pending_pairs.push_back(make_pair(op, 0, 0, 1024, 512, 512, 256, 1024, 1024));
		end

		repeat (800) begin
			kind = $urandom_range(0, 9);
			span = ($urandom_range(0, 7) == 0) ? 4000000 : 8000;
			p.op = OP_BITS'(OP_TOP + $urandom_range(0, 4));
			if (kind < 6) begin
				// nearby boxes or segments: the shape that actually hits
				p.ax = near_coord(span); p.ay = near_coord(span);
				p.bx = near_coord(span / 2); p.by = near_coord(span / 2);
				p.cx = p.ax + near_coord(span / 2); p.cy = p.ay + near_coord(span / 2);
				p.dx = near_coord(span / 2); p.dy = near_coord(span / 2);
				if (p.op == OP_SEG && kind < 3) begin
					// center segment 2 on the midpoint of segment 1
					p.cx = COORD_BITS'(p.ax + p.bx / 2 - p.dx / 2);
					p.cy = COORD_BITS'(p.ay + p.by / 2 - p.dy / 2);
				end
			end else if (kind < 9) begin
				p.ax = any_coord(); p.ay = any_coord(); p.bx = any_coord(); p.by = any_coord();
				p.cx = any_coord(); p.cy = any_coord(); p.dx = any_coord(); p.dy = any_coord();
			end else begin
				// parallel pair or unused opcode
				p.op = ($urandom_range(0, 1) == 0) ? OP_SEG
					: OP_BITS'(OP_SEG + $urandom_range(1, 3));
				p.ax = near_coord(span); p.ay = near_coord(span);
				p.bx = near_coord(span); p.by = near_coord(span);
				p.cx = near_coord(span); p.cy = near_coord(span);
				p.dx = COORD_BITS'(p.bx * 2); p.dy = COORD_BITS'(p.by * 2);
			end
			pending_pairs.push_back(p);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		item.valid = 1'b0;
		item.opcode = '0;
		item.a_x = '0; item.a_y = '0; item.b_x = '0; item.b_y = '0;
		item.c_x = '0; item.c_y = '0; item.d_x = '0; item.d_y = '0;
		result.ready = 1'b0;
		send_gap = 0;
		take_gap = 0;
		mismatches = 0;
		cycles = 0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		pair_t p;
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				p.op = item.opcode;
				p.ax = item.a_x; p.ay = item.a_y; p.bx = item.b_x; p.by = item.b_y;
				p.cx = item.c_x; p.cy = item.c_y; p.dx = item.d_x; p.dy = item.d_y;
				expected_hits.push_back(predict_hit(p));
			end
			if (!item.valid || item.ready) begin
				if (send_gap == 0 && pending_pairs.size() > QUIET_TAIL
						&& $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 8);
				end
				if (send_gap > 0) begin
					send_gap--;
					item.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					p = pending_pairs.pop_front();
					item.valid <= 1'b1;
					item.opcode <= p.op;
					item.a_x <= p.ax; item.a_y <= p.ay; item.b_x <= p.bx; item.b_y <= p.by;
					item.c_x <= p.cx; item.c_y <= p.cy; item.d_x <= p.dx; item.d_y <= p.dy;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			cycles++;
			if (result.valid && result.ready) begin
				if (expected_hits.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result transfer: hit %0b t1 %0d t2 %0d x %0d y %0d",
							result.hit, result.t_first, result.t_second,
							result.point_x, result.point_y);
					end
				end else begin
					want = expected_hits.pop_front();
					if (result.hit !== want.hit || result.t_first !== want.t_first
							|| result.t_second !== want.t_second
							|| result.point_x !== want.point_x
							|| result.point_y !== want.point_y) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected hit %0b t1 %0d t2 %0d x %0d y %0d",
								want.hit, want.t_first, want.t_second,
								want.point_x, want.point_y);
							$display("          actual   hit %0b t1 %0d t2 %0d x %0d y %0d",
								result.hit, result.t_first, result.t_second,
								result.point_x, result.point_y);
						end
					end
				end
			end
			if (take_gap == 0 && pending_pairs.size() > QUIET_TAIL
					&& $urandom_range(0, 5) == 0) begin
				take_gap = $urandom_range(1, 8);
			end
			if (take_gap > 0) begin
				take_gap--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		wait (pending_pairs.size() == 0 && !(item.valid === 1'b1)
			&& expected_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/resi_pkg.sv
rtl/resi_if.sv
rtl/resi_div_cell.sv
rtl/resi_point.sv
rtl/resi_top.sv
dv/tb_rect_edge_segment_intersect_top.sv
